### sv/assert_macros.svh
// Assertion macros shared by the region table RTL.
// Needs a clk in the scope of each use, and an active-high rst for ASSERT_CHK.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ASSERT_CHK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CHK(label, prop)
`define ASSERT_ALL(label, prop)

`endif

`endif

### sv/art_pkg.sv
// Package for the address region table: field widths, op and status codes,
// and the item and result structs. No dependencies.
package art_pkg;

  localparam int OP_W   = 2;
  localparam int ID_W   = 32;
  localparam int ADDR_W = 48;
  localparam int ST_W   = 2;

  // Item ops
  localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE      = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP_ID   = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP_ADDR = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_DUP_ID    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   region_id;
    logic [ADDR_W-1:0] base_address;
    logic [ADDR_W-1:0] region_size;
    logic [ADDR_W-1:0] query_address;
  } art_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   found_id;
    logic [ADDR_W-1:0] found_base;
    logic [ADDR_W-1:0] found_size;
  } art_result_t;

endpackage

### sv/art_table.sv
// Region table storage with parallel id and address match for every slot.
// Depends on art_pkg and assert_macros.svh.
`include "assert_macros.svh"

module art_table #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  art_pkg::art_item_t  item,
  output art_pkg::art_result_t result
);
  import art_pkg::*;

  // Slot storage
  logic [ENTRIES-1:0] slot_valid;
  logic [ID_W-1:0]    slot_id   [ENTRIES];
  logic [ADDR_W-1:0]  slot_base [ENTRIES];
  logic [ADDR_W-1:0]  slot_size [ENTRIES];
  // beats[i][j]: slot i wins over slot j on overlap (lower base, then lower slot)
  logic [ENTRIES-1:0] beats     [ENTRIES];

  logic [ENTRIES-1:0] id_match;
  logic [ENTRIES-1:0] contained;
  logic [ENTRIES-1:0] addr_win;
  logic [ENTRIES-1:0] free_sel;
  logic [ENTRIES-1:0] new_row;
  logic [ENTRIES-1:0] rd_sel;
  logic [ID_W-1:0]    rd_id;
  logic [ADDR_W-1:0]  rd_base;
  logic [ADDR_W-1:0]  rd_size;
  logic               id_hit;
  logic               ins_ok;
  logic               rem_ok;

  // Lowest free slot
  assign free_sel = ~slot_valid & (slot_valid + ENTRIES'(1));
  assign id_hit   = |id_match;

  // Per-slot compare lanes
  for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
    localparam logic [ENTRIES-1:0] SELF  = ENTRIES'(1) << g;
    localparam logic [ENTRIES-1:0] LOWER = SELF - ENTRIES'(1);
    logic [ADDR_W:0] slot_end;

    assign slot_end     = {1'b0, slot_base[g]} + {1'b0, slot_size[g]};
    assign id_match[g]  = slot_valid[g] && (slot_id[g] == item.region_id);
    assign contained[g] = slot_valid[g] && (item.query_address >= slot_base[g])
                          && ({1'b0, item.query_address} < slot_end);
    assign addr_win[g]  = contained[g] && (&(beats[g] | ~contained | SELF));
    // Order of the new region against this slot, new slot index from free_sel
    assign new_row[g]   = (item.base_address < slot_base[g])
                          || ((item.base_address == slot_base[g])
                              && (|(free_sel & LOWER)));
  end

  // Pick the slot that the result reads
  always_comb begin
    unique case (item.op)
      OP_LOOKUP_ADDR: rd_sel = addr_win;
      default:        rd_sel = id_match;
    endcase
  end

  // Read mux over one-hot select
  always_comb begin
    rd_id   = '0;
    rd_base = '0;
    rd_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_id   = rd_id   | ({ID_W{rd_sel[i]}}   & slot_id[i]);
      rd_base = rd_base | ({ADDR_W{rd_sel[i]}} & slot_base[i]);
      rd_size = rd_size | ({ADDR_W{rd_sel[i]}} & slot_size[i]);
    end
  end

  // Decode the op into a result
  always_comb begin
    result = '0;
    unique case (item.op)
      OP_INSERT: begin
        if (id_hit) begin
          result.status = ST_DUP_ID;
        end else if (!(|free_sel)) begin
          result.status = ST_FULL;
        end else begin
          result.status     = ST_OK;
          result.found_id   = item.region_id;
          result.found_base = item.base_address;
          result.found_size = item.region_size;
        end
      end
      OP_REMOVE, OP_LOOKUP_ID: begin
        if (id_hit) begin
          result.status     = ST_OK;
          result.found_id   = rd_id;
          result.found_base = rd_base;
          result.found_size = rd_size;
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (|addr_win) begin
          result.status     = ST_OK;
          result.found_id   = rd_id;
          result.found_base = rd_base;
          result.found_size = rd_size;
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign ins_ok = commit && (item.op == OP_INSERT) && !id_hit && (|free_sel);
  assign rem_ok = commit && (item.op == OP_REMOVE) && id_hit;

  // Valid bits: set on insert, drop on remove
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ins_ok) begin
      slot_valid <= slot_valid | free_sel;
    end else if (rem_ok) begin
      slot_valid <= slot_valid & ~id_match;
    end
  end

  // Slot contents and overlap order, written on insert only
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (ins_ok && free_sel[i]) begin
        slot_id[i]   <= item.region_id;
        slot_base[i] <= item.base_address;
        slot_size[i] <= item.region_size;
        beats[i]     <= new_row;
      end
      for (int j = 0; j < ENTRIES; j++) begin
        if (ins_ok && free_sel[i] && (i != j)) begin
          beats[j][i] <= ~new_row[j];
        end
      end
    end
  end

  // Ids stay unique, so at most one slot matches an id
  `ASSERT_CHK(a_id_unique, $onehot0(id_match))
  // Overlap order picks a single winner
  `ASSERT_CHK(a_addr_single, $onehot0(addr_win))
  // Table full only when every slot holds a region
  `ASSERT_CHK(a_full_real, (commit && result.status == ST_FULL) |-> (&slot_valid))
  // A good insert adds exactly one region
  `ASSERT_CHK(a_insert_count,
    ins_ok |=> ($countones(slot_valid) == $past($countones(slot_valid)) + 1))

endmodule

### sv/address_region_table_unit.sv
// Top level of the address region table: input register, table, result register.
// Depends on art_pkg, art_table and assert_macros.svh.
//
//   channel  handshake              payload
//   input    in_valid / in_stall    op, region_id, base_address, region_size,
//                                   query_address
//   output   out_valid / out_stall  status, found_id, found_base, found_size
//
// One item per clock while not stalled; each item passes the input register, then the result register.
// All ENTRIES slots are compared in parallel, and the table is written in the
// same cycle that the result is registered, so the next item sees the update.
// Reset clears the slot valid bits and both pipeline valids.
// A stall on the output holds the result register; a full input register then holds too and stalls the input.
`include "assert_macros.svh"

module address_region_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [art_pkg::OP_W-1:0]      op,
  input  logic [art_pkg::ID_W-1:0]      region_id,
  input  logic [art_pkg::ADDR_W-1:0]    base_address,
  input  logic [art_pkg::ADDR_W-1:0]    region_size,
  input  logic [art_pkg::ADDR_W-1:0]    query_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [art_pkg::ST_W-1:0]      status,
  output logic [art_pkg::ID_W-1:0]      found_id,
  output logic [art_pkg::ADDR_W-1:0]    found_base,
  output logic [art_pkg::ADDR_W-1:0]    found_size
);
  import art_pkg::*;

  art_item_t   item;
  logic        item_valid;
  art_result_t result;
  art_result_t result_q;
  logic        advance;
  logic        commit;
  logic        take;

  // Result register free or draining this cycle
  assign advance  = !out_valid || !out_stall;
  assign commit   = item_valid && advance;
  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance || !item_valid) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.op            <= op;
      item.region_id     <= region_id;
      item.base_address  <= base_address;
      item.region_size   <= region_size;
      item.query_address <= query_address;
    end
  end

  art_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result_q <= result;
    end
  end

  assign status     = result_q.status;
  assign found_id   = result_q.found_id;
  assign found_base = result_q.found_base;
  assign found_size = result_q.found_size;

  // An item in the input register reaches the output next cycle unless stalled
  `ASSERT_CHK(a_move, commit |=> out_valid)
  // Input stall only while the output side holds a result
  `ASSERT_CHK(a_stall_cause, in_stall |-> (out_valid && out_stall))
  // Nothing pending right after reset
  `ASSERT_ALL(a_reset_clear, rst |=> (!out_valid && !item_valid))

endmodule

### tb/address_region_table_unit_tb.sv
// Self-checking testbench for address_region_table_unit: a queue-fed driver, a result
// monitor and an in-order table predictor, with phased idling and back-pressure.
// Depends on art_pkg and the address_region_table_unit RTL.
`timescale 1ns / 100ps

module address_region_table_unit_tb;
  import art_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_POOL_N = 24;
  localparam int BASE_POOL_N = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [ID_W-1:0] ID_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = '0;
  logic [ID_W-1:0] region_id = '0;
  logic [ADDR_W-1:0] base_address = '0;
  logic [ADDR_W-1:0] region_size = '0;
  logic [ADDR_W-1:0] query_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] status;
  logic [ID_W-1:0] found_id;
  logic [ADDR_W-1:0] found_base;
  logic [ADDR_W-1:0] found_size;

  always #1 clk = ~clk;

  address_region_table_unit #(
    .ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .region_id(region_id),
    .base_address(base_address),
    .region_size(region_size),
    .query_address(query_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .found_id(found_id),
    .found_base(found_base),
    .found_size(found_size)
  );

  // Predicted table contents
  bit slot_live[TABLE_DEPTH];
  logic [ID_W-1:0] slot_rid[TABLE_DEPTH];
  logic [ADDR_W-1:0] slot_lo[TABLE_DEPTH];
  logic [ADDR_W-1:0] slot_len[TABLE_DEPTH];

  art_item_t pending_items[$];
  art_result_t expected_results[$];
  art_item_t cur_item;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int result_count = 0;
  int cycle_count = 0;

  // Stimulus pools: a small id set so inserts collide, removes hit and the table fills
  logic [ID_W-1:0] id_pool[ID_POOL_N];
  logic [ADDR_W-1:0] base_pool[BASE_POOL_N];
  logic [ADDR_W-1:0] recent_lo[BASE_POOL_N];
  logic [ADDR_W-1:0] recent_len[BASE_POOL_N];
  int recent_wr = 0;

  function automatic int slot_of_id(input logic [ID_W-1:0] id);
    int hit;
    hit = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_rid[i] == id) hit = i;
    end
    return hit;
  endfunction

  // Apply one item to the predicted table and return the result it gives
  function automatic art_result_t table_apply(input art_item_t it);
    art_result_t r;
    int hit;
    logic [ADDR_W:0] q;
    logic [ADDR_W:0] lo;
    logic [ADDR_W:0] hi;
    r = '0;
    hit = -1;
    case (it.op)
      OP_INSERT: begin
        if (slot_of_id(it.region_id) >= 0) begin
          r.status = ST_DUP_ID;
        end else begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_live[i]) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_live[hit] = 1'b1;
            slot_rid[hit] = it.region_id;
            slot_lo[hit] = it.base_address;
            slot_len[hit] = it.region_size;
            r.status = ST_OK;
          end
        end
      end
      OP_REMOVE: begin
        hit = slot_of_id(it.region_id);
        r.status = (hit < 0) ? ST_NOT_FOUND : ST_OK;
        // contents stay readable below; only the valid bit goes
        if (hit >= 0) slot_live[hit] = 1'b0;
      end
      OP_LOOKUP_ID: begin
        hit = slot_of_id(it.region_id);
        r.status = (hit < 0) ? ST_NOT_FOUND : ST_OK;
      end
      default: begin
        // half-open range, end formed one bit wider so it never wraps
        q = {1'b0, it.query_address};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          lo = {1'b0, slot_lo[i]};
          hi = lo + {1'b0, slot_len[i]};
          if (slot_live[i] && q >= lo && q < hi &&
              (hit < 0 || slot_lo[i] < slot_lo[hit])) hit = i;
        end
        r.status = (hit < 0) ? ST_NOT_FOUND : ST_OK;
      end
    endcase
    if (r.status == ST_OK) begin
      r.found_id = slot_rid[hit];
      r.found_base = slot_lo[hit];
      r.found_size = slot_len[hit];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ADDR_MAX;
      2, 3: return rand_addr();
      default: return ADDR_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // Aim queries at region edges most of the time
  function automatic logic [ADDR_W-1:0] pick_query();
    int k;
    k = $urandom_range(0, BASE_POOL_N - 1);
    case ($urandom_range(0, 7))
      0: return rand_addr();
      1: return base_pool[k];
      2: return recent_lo[k];
      3: return recent_lo[k] + recent_len[k] - 1'b1;
      4: return recent_lo[k] + recent_len[k];
      5: return recent_lo[k] - 1'b1;
      default: return recent_lo[k] + ADDR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id);
    art_item_t it;
    it.op = o;
    it.region_id = id;
    it.base_address = ($urandom_range(0, 1) == 0) ?
                      base_pool[$urandom_range(0, BASE_POOL_N - 1)] : rand_addr();
    it.region_size = pick_size();
    it.query_address = pick_query();
    if (o == OP_INSERT) begin
      recent_lo[recent_wr] = it.base_address;
      recent_len[recent_wr] = it.region_size;
      recent_wr = (recent_wr + 1) % BASE_POOL_N;
    end
    pending_items.push_back(it);
  endtask

  task automatic push_directed(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
                               input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] len,
                               input logic [ADDR_W-1:0] q);
    art_item_t it;
    it.op = o;
    it.region_id = id;
    it.base_address = lo;
    it.region_size = len;
    it.query_address = q;
    pending_items.push_back(it);
  endtask

  // Mostly single ops on pooled ids, with fill and clear bursts and some raw noise
  task automatic push_random(input int n);
    int made;
    int sel;
    int w;
    logic [OP_W-1:0] o;
    logic [ID_W-1:0] id;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        foreach (id_pool[i]) push_item(OP_INSERT, id_pool[i]);
        made += ID_POOL_N;
      end else if (sel < 14) begin
        foreach (id_pool[i]) push_item(OP_REMOVE, id_pool[i]);
        made += ID_POOL_N;
      end else if (sel < 24) begin
        push_directed(OP_W'($urandom_range(0, 3)), $urandom(), rand_addr(), rand_addr(),
                      rand_addr());
        made++;
      end else begin
        w = $urandom_range(0, 99);
        if (w < 35) o = OP_INSERT;
        else if (w < 55) o = OP_REMOVE;
        else if (w < 75) o = OP_LOOKUP_ID;
        else o = OP_LOOKUP_ADDR;
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom()) :
             id_pool[$urandom_range(0, ID_POOL_N - 1)];
        push_item(o, id);
        made++;
      end
    end
  endtask

  task automatic wait_queue_drained();
    while (pending_items.size() != 0) @(negedge clk);
  endtask

  task automatic wait_all_done();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(table_apply(cur_item));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          op <= cur_item.op;
          region_id <= cur_item.region_id;
          base_address <= cur_item.base_address;
          region_size <= cur_item.region_size;
          query_address <= cur_item.query_address;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    art_result_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: none expected, got st=%0d id=%h base=%h size=%h",
                   result_count, status, found_id, found_base, found_size);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || found_id !== want.found_id ||
            found_base !== want.found_base || found_size !== want.found_size) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected st=%0d id=%h base=%h size=%h, got st=%0d id=%h base=%h size=%h",
                     result_count, want.status, want.found_id, want.found_base,
                     want.found_size, status, found_id, found_base, found_size);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    for (int i = 2; i < ID_POOL_N; i++) id_pool[i] = $urandom();
    base_pool[0] = '0;
    base_pool[1] = ADDR_MAX;
    base_pool[2] = ADDR_W'(48'h1000);
    for (int i = 3; i < BASE_POOL_N; i++) base_pool[i] = rand_addr();
    for (int i = 0; i < BASE_POOL_N; i++) begin
      recent_lo[i] = base_pool[i];
      recent_len[i] = ADDR_W'(48'h100);
    end
    @(negedge clk);

    // Empty table, field extremes, duplicates, overlap ties, zero size, top of space
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, '0);
    push_directed(OP_LOOKUP_ID, ID_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX);
    push_directed(OP_REMOVE, '0, '0, '0, '0);
    push_directed(OP_INSERT, '0, '0, ADDR_MAX, '0);
    push_directed(OP_INSERT, ID_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX);
    push_directed(OP_INSERT, '0, ADDR_W'(48'h55), ADDR_W'(48'h10), '0);
    push_directed(OP_INSERT, ID_W'(5), ADDR_W'(48'h1000), '0, '0);
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_W'(48'h1000));
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_MAX);
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_MAX - 1'b1);
    push_directed(OP_LOOKUP_ID, ID_W'(5), '0, '0, '0);
    push_directed(OP_INSERT, ID_W'(7), '0, ADDR_W'(48'h10), '0);
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_W'(48'h5));
    push_directed(OP_REMOVE, '0, '0, '0, '0);
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_W'(48'h5));
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_W'(48'h10));
    push_directed(OP_LOOKUP_ID, '0, '0, '0, '0);
    push_directed(OP_REMOVE, ID_W'(5), '0, '0, '0);
    push_directed(OP_REMOVE, ID_W'(7), '0, '0, '0);
    push_directed(OP_REMOVE, ID_MAX, '0, '0, '0);
    push_directed(OP_LOOKUP_ADDR, '0, '0, '0, ADDR_MAX);
    wait_queue_drained();

    // Full rate
    push_random(300);
    wait_queue_drained();

    // Hold off the output while items keep coming, then let everything drain
    hold_asked = hold_asked + 1;
    push_random(40);
    wait_all_done();

    send_idle_pct = 82;
    push_random(300);
    wait_queue_drained();

    send_idle_pct = 0;
    recv_stall_pct = 82;
    push_random(300);
    wait_queue_drained();

    send_idle_pct = 12;
    recv_stall_pct = 12;
    push_random(260);
    wait_all_done();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
